### rtl/jlpr_pkg.sv
// Package with the shared types and constants of the joypad line packet receiver.
package jlpr_pkg;

	localparam int PAD_W = 8;
	localparam int NIB_W = 4;
	localparam int IDX_OUT_W = 4;
	localparam int REG_INDEX_W = 4;
	localparam int BIT_CNT_W = 3;

	localparam logic [NIB_W-1:0] NIB_ALL = 4'hf;
	localparam logic [4:0] MP_REQ_CMD = 5'h11;
	localparam logic [1:0] LAST_PLAYER = 2'd3;
	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

	typedef enum logic [1:0] {
		MODE_ONE = 2'd0,
		MODE_TWO = 2'd1,
		MODE_FOUR = 2'd2,
		MODE_FOUR_ALT = 2'd3
	} player_mode_t;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_PAD_ONE = 4'd0,
		REG_PAD_TWO = 4'd1,
		REG_PAD_THREE = 4'd2,
		REG_PAD_FOUR = 4'd3
	} reg_index_t;

	typedef struct packed {
		logic shift;
		logic load;
	} chain_ctl_t;

endpackage

### rtl/jlpr_line_if.sv
// Channel interfaces for the select line writes and the result words.
interface jlpr_line_if;
	logic valid;
	logic ready;
	logic select_dpad;
	logic select_buttons;

	modport source (output valid, output select_dpad, output select_buttons, input ready);
	modport sink (input valid, input select_dpad, input select_buttons, output ready);
endinterface

interface jlpr_result_if;
	logic valid;
	logic ready;
	logic [3:0] joyp_nibble;
	logic byte_valid;
	logic [7:0] packet_byte;
	logic [3:0] byte_index;
	logic last;

	modport source (output valid, output joyp_nibble, output byte_valid, output packet_byte,
		output byte_index, output last, input ready);
	modport sink (input valid, input joyp_nibble, input byte_valid, input packet_byte,
		input byte_index, input last, output ready);
endinterface

### rtl/jlpr_cell.sv
// One byte cell of the packet chain.
module jlpr_cell (
	input  logic                      clk,
	input  logic                      shift,
	input  logic [jlpr_pkg::PAD_W-1:0] d,
	output logic [jlpr_pkg::PAD_W-1:0] q
);

	logic [jlpr_pkg::PAD_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

### rtl/jlpr_chain.sv
// Row of byte cells that collects packet bytes and rotates them out from the head.
module jlpr_chain #(
	parameter int PACKET_BYTES = 16
) (
	input  logic                       clk,
	input  jlpr_pkg::chain_ctl_t       ctl,
	input  logic [jlpr_pkg::PAD_W-1:0] new_byte,
	output logic [jlpr_pkg::PAD_W-1:0] head_byte,
	output logic [jlpr_pkg::PAD_W-1:0] second_byte
);

	localparam int SECOND = (PACKET_BYTES > 1) ? 1 : 0;

	logic [jlpr_pkg::PAD_W-1:0] cell_q [PACKET_BYTES];
	logic [jlpr_pkg::PAD_W-1:0] cell_d [PACKET_BYTES];

	for (genvar k = 0; k < PACKET_BYTES; k++) begin : g_cell
		if (k == PACKET_BYTES - 1) begin : g_tail
			assign cell_d[k] = ctl.load ? new_byte : cell_q[0];
		end else begin : g_body
			assign cell_d[k] = cell_q[k+1];
		end

		jlpr_cell u_cell (
			.clk   (clk),
			.shift (ctl.shift),
			.d     (cell_d[k]),
			.q     (cell_q[k])
		);
	end

	assign head_byte = cell_q[0];
	assign second_byte = cell_q[SECOND];

endmodule

### rtl/joypad_line_packet_receiver_top.sv
// Top level of the joypad line packet receiver.
//
// Each accepted line word yields one result word with the joypad nibble; a word
// that carries the stop bit of a complete packet yields that word followed by the
// packet bytes, one result word per cycle while the sink is ready. The byte rate is
// set by the single output register and the byte chain, which rotates one byte to
// its head per cycle while the sink is ready. No new line word is taken until the
// last packet byte is loaded.
module joypad_line_packet_receiver_top #(
	parameter int PACKET_BYTES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	jlpr_line_if.sink                        line,
	jlpr_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [jlpr_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [jlpr_pkg::PAD_W-1:0]       cfg_data
);

	localparam int CNT_W = $clog2(PACKET_BYTES + 1);
	localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(PACKET_BYTES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PACKET_BYTES);

	logic [jlpr_pkg::PAD_W-1:0] pad_q [4];
	logic dpad_lock_q, btn_lock_q;
	logic [1:0] player_idx_q;
	jlpr_pkg::player_mode_t player_mode_q;
	logic await_q, strobe_q, full_q;
	logic [jlpr_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [CNT_W-1:0] byte_cnt_q;
	logic [jlpr_pkg::PAD_W-1:0] shift_q;
	logic emit_q;
	logic [CNT_W-1:0] emit_cnt_q;
	logic out_valid_q;
	logic [jlpr_pkg::NIB_W-1:0] nib_q;
	logic byte_valid_q, last_q;
	logic [jlpr_pkg::PAD_W-1:0] byte_q;
	logic [jlpr_pkg::IDX_OUT_W-1:0] index_q;

	logic acc, p14, p15, step, slot_free, emit_fire;
	logic [1:0] inc_idx, idx_n;
	jlpr_pkg::player_mode_t mode_n;
	logic [jlpr_pkg::PAD_W-1:0] pad;
	logic [jlpr_pkg::NIB_W-1:0] nib;
	logic dl_n, bl_n, await_n, strobe_n, full_n, emit_n, store_byte;
	logic [jlpr_pkg::BIT_CNT_W-1:0] bit_cnt_n;
	logic [CNT_W-1:0] byte_cnt_n, byte_inc;
	logic [jlpr_pkg::PAD_W-1:0] shift_n;
	logic [jlpr_pkg::PAD_W-1:0] head_byte, second_byte;
	jlpr_pkg::chain_ctl_t chain_ctl;

	assign p14 = line.select_dpad;
	assign p15 = line.select_buttons;
	assign slot_free = !out_valid_q || result.ready;
	assign line.ready = !emit_q && slot_free;
	assign acc = line.valid && line.ready;
	assign emit_fire = emit_q && slot_free;

	always_comb begin
		step = p14 && p15 && !dpad_lock_q && !btn_lock_q;
		inc_idx = player_idx_q + 2'd1;
		idx_n = player_idx_q;
		mode_n = player_mode_q;
		if (step) begin
			case (player_mode_q)
				jlpr_pkg::MODE_ONE: idx_n = 2'd0;
				jlpr_pkg::MODE_TWO: idx_n = {1'b0, inc_idx[0]};
				default: idx_n = inc_idx;
			endcase
		end
		pad = pad_q[idx_n];
		nib = jlpr_pkg::NIB_ALL;
		if (p14 && p15) begin
			nib = jlpr_pkg::NIB_ALL - {2'b00, idx_n};
		end
		if (!p14) begin
			nib = nib & pad[3:0];
		end
		if (!p15) begin
			nib = nib & pad[7:4];
		end

		dl_n = step ? 1'b1 : dpad_lock_q;
		bl_n = step ? 1'b1 : btn_lock_q;
		if (!p15 && p14) begin
			bl_n = 1'b0;
		end
		if (p15 && !p14) begin
			dl_n = 1'b0;
		end

		await_n = await_q;
		strobe_n = strobe_q;
		full_n = full_q;
		bit_cnt_n = bit_cnt_q;
		byte_cnt_n = byte_cnt_q;
		shift_n = shift_q;
		emit_n = 1'b0;
		store_byte = 1'b0;
		byte_inc = byte_cnt_q + CNT_W'(1);
		if (!p14 && !p15) begin
			await_n = 1'b0;
			byte_cnt_n = '0;
			bit_cnt_n = '0;
			strobe_n = 1'b1;
			full_n = 1'b0;
		end else if (await_q) begin
			await_n = 1'b1;
		end else if (p14 && p15) begin
			strobe_n = 1'b0;
		end else if (strobe_q) begin
			full_n = 1'b0;
			await_n = 1'b1;
			bit_cnt_n = '0;
			byte_cnt_n = '0;
		end else begin
			strobe_n = 1'b1;
			if (full_q) begin
				if (p15) begin
					if (head_byte[7:3] == jlpr_pkg::MP_REQ_CMD) begin
						mode_n = jlpr_pkg::player_mode_t'(second_byte[1:0]);
						idx_n = jlpr_pkg::LAST_PLAYER;
					end
					emit_n = 1'b1;
					full_n = 1'b0;
					await_n = 1'b1;
				end
			end else begin
				shift_n = {!p15, shift_q[7:1]};
				bit_cnt_n = bit_cnt_q + jlpr_pkg::BIT_CNT_W'(1);
				if (bit_cnt_q == jlpr_pkg::LAST_BIT) begin
					store_byte = 1'b1;
					byte_cnt_n = byte_inc;
					if (byte_inc >= FULL_CNT) begin
						full_n = 1'b1;
					end
				end
			end
		end

		chain_ctl.shift = (acc && store_byte) || emit_fire;
		chain_ctl.load = acc && store_byte;
	end

	jlpr_chain #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_chain (
		.clk         (clk),
		.ctl         (chain_ctl),
		.new_byte    (shift_n),
		.head_byte   (head_byte),
		.second_byte (second_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pad_q[i] <= '1;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				jlpr_pkg::REG_PAD_ONE: pad_q[0] <= cfg_data;
				jlpr_pkg::REG_PAD_TWO: pad_q[1] <= cfg_data;
				jlpr_pkg::REG_PAD_THREE: pad_q[2] <= cfg_data;
				jlpr_pkg::REG_PAD_FOUR: pad_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpad_lock_q <= 1'b0;
			btn_lock_q <= 1'b0;
			player_idx_q <= '0;
			player_mode_q <= jlpr_pkg::MODE_ONE;
			await_q <= 1'b1;
			strobe_q <= 1'b0;
			full_q <= 1'b0;
			bit_cnt_q <= '0;
			byte_cnt_q <= '0;
			shift_q <= '0;
		end else if (acc) begin
			dpad_lock_q <= dl_n;
			btn_lock_q <= bl_n;
			player_idx_q <= idx_n;
			player_mode_q <= mode_n;
			await_q <= await_n;
			strobe_q <= strobe_n;
			full_q <= full_n;
			bit_cnt_q <= bit_cnt_n;
			byte_cnt_q <= byte_cnt_n;
			shift_q <= shift_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			emit_q <= 1'b0;
			emit_cnt_q <= '0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
			emit_q <= emit_n;
			emit_cnt_q <= '0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
			emit_q <= (emit_cnt_q != LAST_BYTE);
			emit_cnt_q <= emit_cnt_q + CNT_W'(1);
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nib_q <= nib;
			byte_valid_q <= 1'b0;
			byte_q <= '0;
			index_q <= '0;
			last_q <= !emit_n;
		end else if (emit_fire) begin
			byte_valid_q <= 1'b1;
			byte_q <= head_byte;
			index_q <= jlpr_pkg::IDX_OUT_W'(emit_cnt_q);
			last_q <= (emit_cnt_q == LAST_BYTE);
		end
	end

	assign result.valid = out_valid_q;
	assign result.joyp_nibble = nib_q;
	assign result.byte_valid = byte_valid_q;
	assign result.packet_byte = byte_q;
	assign result.byte_index = index_q;
	assign result.last = last_q;

endmodule
